// File: rtl/vnl_pkg.sv
`timescale 1ns / 1ps
package vnl_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int FRACTION_BITS = 16;
    localparam int IDX_W         = 8;
    localparam int VAL_W         = 18;
    localparam int COORD_W       = 32;
    localparam logic [31:0] FILL_SEED = 32'h6D6F6953;

    localparam logic [1:0] DIM_X = 2'd0;
    localparam logic [1:0] DIM_Y = 2'd1;
    localparam logic [1:0] DIM_Z = 2'd2;
    localparam logic [1:0] DIM_T = 2'd3;

    typedef struct packed {
        logic             fill_val_we;
        logic             fill_perm_we;
        logic [IDX_W-1:0] fill_addr;
        logic             load;
        logic             prd;
        logic [1:0]       hsel;
        logic             vrd;
        logic [3:0]       corner;
        logic             take;
        logic             push;
        logic             mul;
        logic             add;
        logic [1:0]       lvl;
    } t_cmd;

    function automatic logic [31:0] f_xorshift(input logic [31:0] s);
        logic [31:0] a;
        a = s ^ (s << 13);
        a = a ^ (a >> 17);
        a = a ^ (a << 5);
        return a;
    endfunction

    // round(v * 2^17 / 0xFFFFFF) - 2^16, reciprocal estimate plus one correction
    function automatic logic signed [VAL_W-1:0] f_fill_value(input logic [23:0] v);
        logic [41:0] num;
        logic [41:0] est;
        logic [17:0] q;
        logic [41:0] rem;
        num = {1'b0, v, 17'd0} + 42'h7FFFFF;
        est = (num + (num >> 24)) >> 24;
        q   = est[17:0];
        rem = num - (({24'd0, q} << 24) - {24'd0, q});
        if (rem >= 42'hFFFFFF) begin
            q = q + 18'd1;
        end
        return $signed(q - 18'd65536);
    endfunction

endpackage

// File: rtl/vnl_ctrl.sv
`timescale 1ns / 1ps
module vnl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_valid,
    output vnl_pkg::t_cmd o_cmd
);
    import vnl_pkg::*;

    localparam logic [3:0] S_FILL  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HT    = 4'd2;
    localparam logic [3:0] S_HZ    = 4'd3;
    localparam logic [3:0] S_HY    = 4'd4;
    localparam logic [3:0] S_HX    = 4'd5;
    localparam logic [3:0] S_HV    = 4'd6;
    localparam logic [3:0] S_TAKE  = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_ADD   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state, n_state;
    logic [8:0] r_cnt, n_cnt;
    logic [3:0] r_corner, n_corner;
    logic [1:0] r_lvl, n_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_cnt    <= '0;
            r_corner <= '0;
            r_lvl    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_corner <= n_corner;
            r_lvl    <= n_lvl;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_corner = r_corner;
        n_lvl    = r_lvl;
        o_busy   = 1'b1;
        o_valid  = 1'b0;
        o_cmd    = '0;
        o_cmd.corner    = r_corner;
        o_cmd.lvl       = r_lvl;
        o_cmd.fill_addr = r_cnt[8:1];
        case (r_state)
            S_FILL: begin
                o_cmd.fill_val_we  = ~r_cnt[0];
                o_cmd.fill_perm_we = r_cnt[0];
                n_cnt = r_cnt + 9'd1;
                if (r_cnt == 9'd511) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_corner   = '0;
                    n_lvl      = '0;
                    n_state    = S_HT;
                end
            end
            S_HT: begin
                o_cmd.prd  = 1'b1;
                o_cmd.hsel = DIM_T;
                n_state    = S_HZ;
            end
            S_HZ: begin
                o_cmd.prd  = 1'b1;
                o_cmd.hsel = DIM_Z;
                n_state    = S_HY;
            end
            S_HY: begin
                o_cmd.prd  = 1'b1;
                o_cmd.hsel = DIM_Y;
                n_state    = S_HX;
            end
            S_HX: begin
                o_cmd.prd  = 1'b1;
                o_cmd.hsel = DIM_X;
                n_state    = S_HV;
            end
            S_HV: begin
                o_cmd.vrd = 1'b1;
                n_state   = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_lvl      = '0;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (!r_corner[r_lvl]) begin
                    o_cmd.push = 1'b1;
                    n_corner   = r_corner + 4'd1;
                    n_state    = S_HT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_lvl == 2'd3) begin
                    n_state = S_DONE;
                end else begin
                    n_lvl   = r_lvl + 2'd1;
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/vnl_dp.sv
`timescale 1ns / 1ps
module vnl_dp #(
    parameter int FRAC_BITS = vnl_pkg::FRACTION_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vnl_pkg::t_cmd                      i_cmd,
    input  logic [vnl_pkg::COORD_W-1:0]        i_coord_x,
    input  logic [vnl_pkg::COORD_W-1:0]        i_coord_y,
    input  logic [vnl_pkg::COORD_W-1:0]        i_coord_z,
    input  logic [vnl_pkg::COORD_W-1:0]        i_coord_time,
    output logic signed [vnl_pkg::VAL_W-1:0]   o_value
);
    import vnl_pkg::*;

    localparam int DW = VAL_W + 1;
    localparam int PW = DW + FRAC_BITS + 1;

    logic [31:0]              r_gen;
    logic [31:0]              gen_next;
    logic signed [VAL_W-1:0]  r_lv [TABLE_ENTRIES];
    logic [IDX_W-1:0]         r_pm [TABLE_ENTRIES];
    logic [IDX_W-1:0]         r_pq;
    logic signed [VAL_W-1:0]  r_vq;
    logic [IDX_W-1:0]         r_ip [4];
    logic [FRAC_BITS-1:0]     r_fr [4];
    logic signed [VAL_W-1:0]  r_cur;
    logic signed [VAL_W-1:0]  r_pend [4];
    logic signed [PW-1:0]     r_prod;
    logic [IDX_W-1:0]         paddr;
    logic signed [DW-1:0]     diff;
    logic signed [FRAC_BITS:0] frac;
    logic signed [PW-1:0]     rsum;
    logic signed [PW-1:0]     step;

    assign gen_next = f_xorshift(r_gen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= FILL_SEED;
        end else if (i_cmd.fill_val_we || i_cmd.fill_perm_we) begin
            r_gen <= gen_next;
        end
    end

    always_comb begin
        paddr = r_ip[i_cmd.hsel] + IDX_W'(i_cmd.corner[i_cmd.hsel]);
        if (i_cmd.hsel != DIM_T) begin
            paddr = paddr + r_pq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_perm_we) begin
            r_pm[i_cmd.fill_addr] <= gen_next[IDX_W-1:0];
        end
        if (i_cmd.prd) begin
            r_pq <= r_pm[paddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_val_we) begin
            r_lv[i_cmd.fill_addr] <= f_fill_value(gen_next[23:0]);
        end
        if (i_cmd.vrd) begin
            r_vq <= r_lv[r_pq];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ip[0] <= i_coord_x[FRAC_BITS+IDX_W-1:FRAC_BITS];
            r_ip[1] <= i_coord_y[FRAC_BITS+IDX_W-1:FRAC_BITS];
            r_ip[2] <= i_coord_z[FRAC_BITS+IDX_W-1:FRAC_BITS];
            r_ip[3] <= i_coord_time[FRAC_BITS+IDX_W-1:FRAC_BITS];
            r_fr[0] <= i_coord_x[FRAC_BITS-1:0];
            r_fr[1] <= i_coord_y[FRAC_BITS-1:0];
            r_fr[2] <= i_coord_z[FRAC_BITS-1:0];
            r_fr[3] <= i_coord_time[FRAC_BITS-1:0];
        end
    end

    // lerp: pend + floor(((cur - pend) * f + half) / 2^FRAC_BITS)
    always_comb begin
        diff = DW'(r_cur) - DW'(r_pend[i_cmd.lvl]);
        frac = $signed({1'b0, r_fr[i_cmd.lvl]});
        rsum = r_prod + (PW'(1) <<< (FRAC_BITS - 1));
        step = rsum >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PW'(diff) * PW'(frac);
        end
        if (i_cmd.push) begin
            r_pend[i_cmd.lvl] <= r_cur;
        end
        if (i_cmd.take) begin
            r_cur <= r_vq;
        end else if (i_cmd.add) begin
            r_cur <= r_pend[i_cmd.lvl] + VAL_W'(step);
        end
    end

    assign o_value = r_cur;

endmodule

// File: rtl/value_noise_4d_lattice.sv
`timescale 1ns / 1ps
// 4D value noise on a 256-entry permutation lattice.
// Command channel: drive i_coord_x/y/z/time (signed Q16.16) and raise start;
// the word is taken at a clock edge where start is high and busy is low.
// Result: o_noise_value (signed Q2.16) is shown for one cycle with o_valid
// high; the receiver must take it then, it cannot stall the block.
// Busy stays high from the accepting edge until o_valid and drops in the cycle
// after o_valid, so a new word is taken only once the last one is done.
// The run time is set by the hash chain: each of the 16 corners makes four
// dependent reads of the single-port permutation memory and one value read,
// and the 15 blends share one multiplier, each in a multiply and an add step.
// Reset: i_rst_n is synchronous, active low. After reset the block runs a
// fill of the value and permutation tables from an xorshift32 generator
// and holds busy high until the fill ends.
module value_noise_4d_lattice #(
    parameter int FRACTION_BITS = vnl_pkg::FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [vnl_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vnl_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vnl_pkg::COORD_W-1:0] i_coord_z,
    input  logic signed [vnl_pkg::COORD_W-1:0] i_coord_time,
    output logic                              o_valid,
    output logic signed [vnl_pkg::VAL_W-1:0]  o_noise_value
);
    import vnl_pkg::*;

    t_cmd cmd;

    vnl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    vnl_dp #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_coord_time (i_coord_time),
        .o_value      (o_noise_value)
    );

endmodule
